>>> design/ptsb_pkg.sv
`default_nettype none
package ptsb_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_FIRED  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  localparam logic [31:0] DEFAULT_INTERVAL_US = 32'd1000;

  // command handed from the front part to the back part
  typedef struct packed {
    action_t     action;
    logic [31:0] interval_us;
    logic        repeat_req;
    logic [5:0]  slot;
    logic [31:0] dt_us;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        last;
    logic        slot_repeat;
    logic [31:0] slot_elapsed;
    logic [31:0] slot_interval;
    logic        ended;
    logic [7:0]  fire_count;
    logic [5:0]  slot_no;
    logic        ok;
    kind_t       kind;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/ptsb_fifo.sv
`default_nettype none
module ptsb_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ptsb_pkg::cmd_t in_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ptsb_pkg::cmd_t     out_cmd
);
  import ptsb_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = mem[rd_ptr];

  // store on write, advance pointers per transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
endmodule
`default_nettype wire

>>> design/ptsb_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module ptsb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  logic [5:0]  cnt;
  logic [31:0] divisor_r;
  logic [33:0] trial;

  // the shifted partial remainder can reach 33 bits, so keep a sign bit above it
  assign trial = {1'b0, remainder, quotient[31]} - {2'b00, divisor_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (start) begin
      busy      <= 1'b1;
      cnt       <= 6'd32;
      quotient  <= dividend;
      remainder <= 32'd0;
      divisor_r <= divisor;
    end else if (busy) begin
      // shift in one bit, subtract when it fits
      if (!trial[33]) begin
        remainder <= trial[31:0];
        quotient  <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= {remainder[30:0], quotient[31]};
        quotient  <= {quotient[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("divider count lost");
endmodule
`default_nettype wire

>>> design/ptsb_back.sv
`default_nettype none
module ptsb_back #(
  parameter int SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire ptsb_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output ptsb_pkg::res_t      res
);
  import ptsb_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] used;
  logic             periodic [SLOTS];
  logic [31:0]      period   [SLOTS];
  logic [31:0]      accum    [SLOTS];

  state_t      state, state_next;
  logic [31:0] cur_dt;
  logic [IW:0] idx;
  logic [IW-1:0] ix;
  logic [31:0] acc_sat;
  logic [32:0] sum;
  logic        div_start, div_busy;
  logic [31:0] quo, rem;
  res_t        res_next;
  logic        load_res;
  logic [IW-1:0] free_ix;
  logic        free_hit;
  logic        sl_hit;
  logic [IW-1:0] sl_ix;

  assign ix    = idx[IW-1:0];
  assign sum   = {1'b0, accum[ix]} + {1'b0, cur_dt};
  assign acc_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign sl_ix = cmd.slot[IW-1:0];
  assign sl_hit = ({26'd0, cmd.slot} < 32'(SLOTS)) && used[sl_ix];

  // lowest free slot
  always_comb begin
    free_ix  = '0;
    free_hit = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_ix  = IW'(i);
        free_hit = 1'b1;
      end
    end
  end

  assign cmd_ready = (state == ST_IDLE) && !res_valid;

  ptsb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(acc_sat),
    .divisor(period[ix]), .busy(div_busy), .quotient(quo), .remainder(rem)
  );

  // next state and result
  always_comb begin
    state_next = state;
    res_next   = '0;
    res_next.ok = 1'b1;
    load_res   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          res_next.last = 1'b1;
          case (cmd.action)
            ACT_CREATE: begin
              res_next.kind    = KIND_CREATE;
              res_next.ok      = free_hit;
              res_next.slot_no = free_hit ? 6'(free_ix) : 6'd0;
              load_res = 1'b1;
            end
            ACT_DELETE: begin
              res_next.kind    = KIND_DELETE;
              res_next.ok      = sl_hit;
              res_next.slot_no = cmd.slot;
              load_res = 1'b1;
            end
            ACT_QUERY: begin
              res_next.kind    = KIND_QUERY;
              res_next.ok      = sl_hit;
              res_next.slot_no = cmd.slot;
              if (sl_hit) begin
                res_next.slot_interval = period[sl_ix];
                res_next.slot_elapsed  = accum[sl_ix];
                res_next.slot_repeat   = periodic[sl_ix];
              end
              load_res = 1'b1;
            end
            ACT_TICK: state_next = ST_SCAN;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!res_valid) begin
          if (idx == (IW+1)'(SLOTS)) begin
            state_next = ST_DONE;
          end else if (used[ix] && acc_sat >= period[ix]) begin
            if (periodic[ix]) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end else begin
              res_next.kind       = KIND_FIRED;
              res_next.slot_no    = 6'(idx);
              res_next.fire_count = 8'd1;
              res_next.ended      = 1'b1;
              load_res = 1'b1;
            end
          end
        end
      end
      ST_DIV: if (!div_busy && !div_start) state_next = ST_EMIT;
      ST_EMIT: begin
        res_next.kind       = KIND_FIRED;
        res_next.slot_no    = 6'(idx);
        res_next.fire_count = (quo > 32'd255) ? 8'd255 : quo[7:0];
        load_res   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_DONE: begin
        if (!res_valid) begin
          res_next.kind = KIND_DONE;
          res_next.last = 1'b1;
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // slot table and walk index
  always_ff @(posedge clk) begin
    if (load_res) res <= res_next;
    if (state == ST_IDLE && cmd_valid && cmd_ready) begin
      cur_dt <= cmd.dt_us;
      idx <= '0;
      if (cmd.action == ACT_CREATE && free_hit) begin
        periodic[free_ix] <= cmd.repeat_req;
        period[free_ix]   <= (cmd.interval_us == 32'd0) ? DEFAULT_INTERVAL_US
                                                        : cmd.interval_us;
        accum[free_ix]    <= 32'd0;
      end
    end
    if (state == ST_SCAN && !res_valid && idx != (IW+1)'(SLOTS)) begin
      if (used[ix]) begin
        if (acc_sat < period[ix]) accum[ix] <= acc_sat;
        else if (!periodic[ix])  accum[ix] <= acc_sat - period[ix];
      end
      if (!(used[ix] && acc_sat >= period[ix] && periodic[ix])) idx <= idx + 1'b1;
    end
    if (state == ST_EMIT) begin
      accum[ix] <= rem;
      idx <= idx + 1'b1;
    end
    if (rst) begin
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load_res) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == ST_IDLE && cmd_valid && cmd_ready) begin
        if (cmd.action == ACT_CREATE && free_hit) used[free_ix] <= 1'b1;
        if (cmd.action == ACT_DELETE && sl_hit) used[sl_ix] <= 1'b0;
      end
      if (state == ST_SCAN && !res_valid && idx != (IW+1)'(SLOTS) && used[ix]
          && acc_sat >= period[ix] && !periodic[ix]) used[ix] <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == ST_IDLE)
    else $error("command taken mid tick");
  a_div_scope: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside division");
endmodule
`default_nettype wire

>>> design/periodic_timer_slot_bank.sv
// periodic_timer_slot_bank: a bank of SLOTS microsecond timer slots.
// Slave channel s_axis_*: one command per transaction (create, delete,
// tick, query). Master channel m_axis_*: result transactions; tlast marks
// the final result of a command. A two-entry command queue decouples the
// front from the slot engine, which handles one command at a time.
// Create, delete and query: the command is registered in the queue,
// then the engine registers the result.
// A tick walks all slots, one slot per cycle while no result waits; a
// one-shot that fires emits a result, and a periodic slot that fires
// first runs the bit-serial divider to count its firings. After the
// walk a done result closes the tick.
// Reset empties the queue and marks every slot free; no clearing pass.
// When the receiver stalls, the result register holds and the engine
// waits; the queue keeps accepting until it holds two commands.
`default_nettype none
module periodic_timer_slot_bank #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: action[1:0], interval_us[33:2], repeat_req[34], slot[40:35],
  // dt_us[72:41], zero fill to 80 bits
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: kind[2:0], ok[3], slot_no[9:4], fire_count[17:10], ended[18],
  // slot_interval[50:19], slot_elapsed[82:51], slot_repeat[83], zero to 88
  output logic [87:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import ptsb_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t res;

  // unpack the incoming command
  assign in_cmd.action      = action_t'(s_axis_tdata[1:0]);
  assign in_cmd.interval_us = s_axis_tdata[33:2];
  assign in_cmd.repeat_req  = s_axis_tdata[34];
  assign in_cmd.slot        = s_axis_tdata[40:35];
  assign in_cmd.dt_us       = s_axis_tdata[72:41];

  ptsb_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(in_cmd), .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  ptsb_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  // pack the result
  assign m_axis_tdata = {4'd0, res.slot_repeat, res.slot_elapsed, res.slot_interval,
                         res.ended, res.fire_count, res.slot_no, res.ok, res.kind};
  assign m_axis_tlast = res.last;

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == KIND_FIRED |-> !m_axis_tlast)
    else $error("fired result marked last");
endmodule
`default_nettype wire
